// ----- rtl/dtc_pkg.sv -----
package dtc_pkg;

  // Default configuration of the block.
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int SIDE_WIDTH_DEF  = 31;

  // Width of the count field in the result beat.
  localparam int COUNT_OUT_W = 7;

  // Control bits that travel with a triple down the cell chain.
  typedef struct packed {
    logic valid;  // the stage holds a triple
    logic last;   // the triple closes its set
    logic live;   // the triple is still unplaced and unmatched
  } dtc_ctl_t;

endpackage

// ----- rtl/distinct_triple_counter_core.sv -----
// Distinct triangle counter.
// Input stream: one beat per triangle. s_tdata carries the three side
// lengths, s_tlast marks the final triangle of a set. Each triple is sorted
// and then travels down a chain of MAX_ENTRIES match cells, one cell per
// cycle. A cell either holds a stored triple, which the passing triple is
// compared with, or is empty and takes the first unmatched triple to reach it.
// A triple that leaves the end of the chain unplaced sets the overflow flag.
// Output stream: one beat per set, sent for the beat with s_tlast, holding
// the number of distinct triples (low bits) and the overflow flag.
// Throughput is one beat per cycle while the output is not stalled; the
// chain accepts a new triangle every cycle and sets may follow one another
// without gaps. The closing beat passes one sort stage, one register per
// cell and the output register before its result beat appears.
// Reset empties every cell and drops any result in flight; no clearing pass
// is needed. When the receiver stalls with a result pending, the whole
// chain and s_tready hold until the result beat is taken.
module distinct_triple_counter_core
  import dtc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int SIDE_WIDTH  = SIDE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // Fields from bit 0 up: side_a, side_b, side_c, zero fill.
  input  logic [((3*SIDE_WIDTH+7)/8)*8-1:0]      s_tdata,
  input  logic                                   s_tlast,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // Fields from bit 0 up: distinct_count (7 bits), overflow (1 bit).
  output logic [7:0]                             m_tdata
);

  localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);

  logic en;

  dtc_ctl_t              ctl [MAX_ENTRIES+1];
  logic [SIDE_WIDTH-1:0] lo  [MAX_ENTRIES+1];
  logic [SIDE_WIDTH-1:0] mid [MAX_ENTRIES+1];
  logic [SIDE_WIDTH-1:0] hi  [MAX_ENTRIES+1];
  logic [COUNT_W-1:0]    cnt [MAX_ENTRIES+1];

  logic                        ovf_acc;
  logic                        ovf_all;
  logic [COUNT_W+COUNT_OUT_W-1:0] cnt_ext;

  // The chain moves whenever the output register can take a new beat.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  dtc_sort #(.SIDE_WIDTH(SIDE_WIDTH)) u_sort (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .side_a   (s_tdata[SIDE_WIDTH-1:0]),
    .side_b   (s_tdata[2*SIDE_WIDTH-1:SIDE_WIDTH]),
    .side_c   (s_tdata[3*SIDE_WIDTH-1:2*SIDE_WIDTH]),
    .ctl      (ctl[0]),
    .lo       (lo[0]),
    .mid      (mid[0]),
    .hi       (hi[0])
  );

  // The running count starts at zero at the head of the chain.
  assign cnt[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    dtc_cell #(.SIDE_WIDTH(SIDE_WIDTH), .COUNT_W(COUNT_W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl[i]),
      .lo_in   (lo[i]),
      .mid_in  (mid[i]),
      .hi_in   (hi[i]),
      .cnt_in  (cnt[i]),
      .ctl_out (ctl[i+1]),
      .lo_out  (lo[i+1]),
      .mid_out (mid[i+1]),
      .hi_out  (hi[i+1]),
      .cnt_out (cnt[i+1])
    );
  end

  // A triple still live past the last cell found no room.
  assign ovf_all = ovf_acc || (ctl[MAX_ENTRIES].valid && ctl[MAX_ENTRIES].live);
  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt[MAX_ENTRIES]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_acc  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctl[MAX_ENTRIES].valid && ctl[MAX_ENTRIES].last;
      if (ctl[MAX_ENTRIES].valid && ctl[MAX_ENTRIES].last) begin
        ovf_acc <= 1'b0;
      end else begin
        ovf_acc <= ovf_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctl[MAX_ENTRIES].valid && ctl[MAX_ENTRIES].last) begin
      m_tdata <= {ovf_all, cnt_ext[COUNT_OUT_W-1:0]};
    end
  end

endmodule

// ----- rtl/dtc_sort.sv -----
module dtc_sort
  import dtc_pkg::*;
#(
  parameter int SIDE_WIDTH = SIDE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic                  in_last,
  input  logic [SIDE_WIDTH-1:0] side_a,
  input  logic [SIDE_WIDTH-1:0] side_b,
  input  logic [SIDE_WIDTH-1:0] side_c,
  output dtc_ctl_t              ctl,
  output logic [SIDE_WIDTH-1:0] lo,
  output logic [SIDE_WIDTH-1:0] mid,
  output logic [SIDE_WIDTH-1:0] hi
);

  logic [SIDE_WIDTH-1:0] a1, b1, b2, c2, a3, b3;

  // Three compare-exchange steps put the sides in ascending order.
  always_comb begin
    a1 = (side_a > side_b) ? side_b : side_a;
    b1 = (side_a > side_b) ? side_a : side_b;
    b2 = (b1 > side_c) ? side_c : b1;
    c2 = (b1 > side_c) ? b1 : side_c;
    a3 = (a1 > b2) ? b2 : a1;
    b3 = (a1 > b2) ? a1 : b2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid <= in_valid;
      ctl.last  <= in_last;
      ctl.live  <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo  <= a3;
      mid <= b3;
      hi  <= c2;
    end
  end

endmodule

// ----- rtl/dtc_cell.sv -----
module dtc_cell
  import dtc_pkg::*;
#(
  parameter int SIDE_WIDTH = SIDE_WIDTH_DEF,
  parameter int COUNT_W    = COUNT_OUT_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  dtc_ctl_t              ctl_in,
  input  logic [SIDE_WIDTH-1:0] lo_in,
  input  logic [SIDE_WIDTH-1:0] mid_in,
  input  logic [SIDE_WIDTH-1:0] hi_in,
  input  logic [COUNT_W-1:0]    cnt_in,
  output dtc_ctl_t              ctl_out,
  output logic [SIDE_WIDTH-1:0] lo_out,
  output logic [SIDE_WIDTH-1:0] mid_out,
  output logic [SIDE_WIDTH-1:0] hi_out,
  output logic [COUNT_W-1:0]    cnt_out
);

  logic                  held;
  logic [SIDE_WIDTH-1:0] held_lo, held_mid, held_hi;
  logic                  match, take, held_after;

  // A live triple either matches this cell's entry, claims the cell if it
  // is empty, or moves on. Cells fill in order, so a later triple always
  // sees what an earlier one left behind.
  always_comb begin
    match      = held && ctl_in.valid && ctl_in.live &&
                 held_lo == lo_in && held_mid == mid_in && held_hi == hi_in;
    take       = ctl_in.valid && ctl_in.live && !held;
    held_after = held || take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 1'b0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
      ctl_out.last  <= ctl_in.last;
      ctl_out.live  <= ctl_in.live && !match && !take;
      // The closing triple is counted first, then the entry is freed.
      if (ctl_in.valid && ctl_in.last) begin
        held <= 1'b0;
      end else if (take) begin
        held <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_out  <= lo_in;
      mid_out <= mid_in;
      hi_out  <= hi_in;
      cnt_out <= cnt_in + {{(COUNT_W-1){1'b0}}, held_after};
      if (take) begin
        held_lo  <= lo_in;
        held_mid <= mid_in;
        held_hi  <= hi_in;
      end
    end
  end

endmodule

// ----- sim/distinct_triple_counter_core_test.sv -----
`timescale 1ns / 1ps

module distinct_triple_counter_core_test;
  import dtc_pkg::*;

  localparam int SW          = SIDE_WIDTH_DEF;
  localparam int MAXE        = MAX_ENTRIES_DEF;
  localparam int TDATA_W     = ((3*SW+7)/8)*8;
  localparam int RAND_ITEMS  = 500;
  localparam int MIN_SETS    = 40;
  localparam int QUIET_LIMIT = 4000;
  localparam int DIR_ROWS    = 20;

  localparam logic [SW-1:0] SIDE_MAX = '1;
  localparam logic [SW-1:0] ALT_ONE  = 31'h5555_5555;
  localparam logic [SW-1:0] ALT_TWO  = 31'h2AAA_AAAA;

  // One triangle as it is sent on the input stream.
  typedef struct packed {
    logic [SW-1:0] a;
    logic [SW-1:0] b;
    logic [SW-1:0] c;
    logic          last;
  } triangle_t;

  // One per-set result as it comes back on the output stream.
  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count;
    logic                   ovf;
  } set_result_t;

  // A directed row: the triangle, and where the outcome is obvious, the
  // result typed in by hand.
  typedef struct packed {
    logic [SW-1:0]          a;
    logic [SW-1:0]          b;
    logic [SW-1:0]          c;
    logic                   last;
    logic                   typed;
    logic [COUNT_OUT_W-1:0] count;
    logic                   ovf;
  } dir_row_t;

  // Directed part. Typed results cover the extremes, pure permutations of one
  // triple and sets of two distinct triples; one set is left to the predictor.
  localparam dir_row_t PLAN [DIR_ROWS] = '{
    '{'0,       '0,       '0,       1'b1, 1'b1, 7'd1, 1'b0},
    '{SIDE_MAX, SIDE_MAX, SIDE_MAX, 1'b1, 1'b1, 7'd1, 1'b0},
    '{31'd3,    31'd4,    31'd5,    1'b0, 1'b0, 7'd0, 1'b0},
    '{31'd3,    31'd5,    31'd4,    1'b0, 1'b0, 7'd0, 1'b0},
    '{31'd4,    31'd3,    31'd5,    1'b0, 1'b0, 7'd0, 1'b0},
    '{31'd4,    31'd5,    31'd3,    1'b0, 1'b0, 7'd0, 1'b0},
    '{31'd5,    31'd3,    31'd4,    1'b0, 1'b0, 7'd0, 1'b0},
    '{31'd5,    31'd4,    31'd3,    1'b1, 1'b1, 7'd1, 1'b0},
    '{'0,       SIDE_MAX, '0,       1'b0, 1'b0, 7'd0, 1'b0},
    '{SIDE_MAX, '0,       '0,       1'b0, 1'b0, 7'd0, 1'b0},
    '{'0,       '0,       SIDE_MAX, 1'b1, 1'b1, 7'd1, 1'b0},
    '{31'd1,    31'd2,    31'd3,    1'b0, 1'b0, 7'd0, 1'b0},
    '{31'd1,    31'd2,    31'd4,    1'b0, 1'b0, 7'd0, 1'b0},
    '{31'd3,    31'd2,    31'd1,    1'b1, 1'b1, 7'd2, 1'b0},
    '{ALT_ONE,  ALT_TWO,  31'd1,    1'b0, 1'b0, 7'd0, 1'b0},
    '{ALT_TWO,  31'd1,    ALT_ONE,  1'b0, 1'b0, 7'd0, 1'b0},
    '{31'd7,    31'd7,    31'd2,    1'b0, 1'b0, 7'd0, 1'b0},
    '{31'd2,    31'd7,    31'd7,    1'b1, 1'b0, 7'd0, 1'b0},
    '{ALT_TWO,  ALT_TWO,  ALT_TWO,  1'b0, 1'b0, 7'd0, 1'b0},
    '{ALT_ONE,  ALT_ONE,  ALT_ONE,  1'b1, 1'b1, 7'd2, 1'b0}
  };

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;
  logic               s_tlast  = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;

  distinct_triple_counter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's triple store for the set in progress. Only the
  // first kept_n entries are ever read, which mirrors the held bits of the cells.
  logic [SW-1:0] kept_lo  [MAXE];
  logic [SW-1:0] kept_mid [MAXE];
  logic [SW-1:0] kept_hi  [MAXE];
  int            kept_n   = 0;
  logic          dropped  = 1'b0;

  set_result_t set_counts_q [$];
  int          errors       = 0;
  int          tx_idle_pct  = 10;
  int          rx_idle_pct  = 50;
  int          quiet_cycles = 0;
  set_result_t got_res;
  set_result_t want_res;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Sorts the triple, looks it up among the kept triples and keeps it if it
  // is new and there is room. Returns 1 with the set's tally when the beat
  // closes its set, and clears the shadow store afterwards.
  function automatic bit tally_triangle(input triangle_t t, output set_result_t res);
    logic [SW-1:0] lo;
    logic [SW-1:0] mid;
    logic [SW-1:0] hi;
    logic [SW-1:0] tmp;
    bit            seen;
    lo   = t.a;
    mid  = t.b;
    hi   = t.c;
    seen = 1'b0;
    res  = '0;
    if (lo > mid) begin
      tmp = lo; lo = mid; mid = tmp;
    end
    if (mid > hi) begin
      tmp = mid; mid = hi; hi = tmp;
    end
    if (lo > mid) begin
      tmp = lo; lo = mid; mid = tmp;
    end
    for (int i = 0; i < kept_n; i++) begin
      if (kept_lo[i] == lo && kept_mid[i] == mid && kept_hi[i] == hi) seen = 1'b1;
    end
    if (!seen) begin
      if (kept_n < MAXE) begin
        kept_lo[kept_n]  = lo;
        kept_mid[kept_n] = mid;
        kept_hi[kept_n]  = hi;
        kept_n++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (!t.last) return 1'b0;
    res.count = kept_n[COUNT_OUT_W-1:0];
    res.ovf   = dropped;
    kept_n    = 0;
    dropped   = 1'b0;
    return 1'b1;
  endfunction

  // Offers one triangle, with random idle cycles ahead of it, and waits for
  // the beat to be taken. A closing beat queues its expected result: the
  // hand-typed one where given, else the predictor's.
  task automatic send_triangle(input triangle_t t, input bit typed, input set_result_t hand);
    logic [TDATA_W-1:0] word;
    set_result_t        res;
    word = '0;
    word[SW-1:0]      = t.a;
    word[2*SW-1:SW]   = t.b;
    word[3*SW-1:2*SW] = t.c;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tlast  <= t.last;
    do @(posedge clk); while (!s_tready);
    if (tally_triangle(t, res)) begin
      if (typed) res = hand;
      set_counts_q = {set_counts_q, res};
    end
  endtask

  // Holds the input stream off until every expected result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (set_counts_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SW-1:0] rand_side();
    case ($urandom_range(7))
      0:       return '0;
      1:       return SIDE_MAX;
      2, 3:    return SW'($urandom_range(15));
      default: return SW'($urandom());
    endcase
  endfunction

  // Random order of the three sides of a triangle.
  function automatic triangle_t permute(input triangle_t t);
    triangle_t    p;
    logic [SW-1:0] tmp;
    p = t;
    case ($urandom_range(2))
      1: begin
        tmp = p.a; p.a = p.b; p.b = p.c; p.c = tmp;
      end
      2: begin
        tmp = p.c; p.c = p.b; p.b = p.a; p.a = tmp;
      end
      default: ;
    endcase
    if ($urandom_range(1)) begin
      tmp = p.a; p.a = p.b; p.b = tmp;
    end
    return p;
  endfunction

  // Output side: the receiver stalls at random and every taken result beat
  // is checked against the oldest expectation. The watchdog counts cycles in
  // which neither stream moves a beat.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (!rst && m_tvalid && m_tready) begin
      got_res.count = m_tdata[COUNT_OUT_W-1:0];
      got_res.ovf   = m_tdata[COUNT_OUT_W];
      if (set_counts_q.size() == 0) begin
        flag_error($sformatf("result count=%0d overflow=%0b with none expected",
                             got_res.count, got_res.ovf));
      end else begin
        want_res = set_counts_q.pop_front();
        if (got_res.count != want_res.count)
          flag_error($sformatf("distinct count %0d, expected %0d",
                               got_res.count, want_res.count));
        if (got_res.ovf != want_res.ovf)
          flag_error($sformatf("overflow flag %0b, expected %0b",
                               got_res.ovf, want_res.ovf));
      end
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    triangle_t   t;
    triangle_t   pool [3];
    triangle_t   big_q [$];
    set_result_t hand;
    int          sent;
    int          set_no;
    int          phase;
    int          new_phase;
    int          set_len;
    int          n_new;
    int          n_rep;
    sent   = 0;
    set_no = 0;
    phase  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows.
    foreach (PLAN[i]) begin
      t          = '{PLAN[i].a, PLAN[i].b, PLAN[i].c, PLAN[i].last};
      hand.count = PLAN[i].count;
      hand.ovf   = PLAN[i].ovf;
      send_triangle(t, PLAN[i].typed, hand);
    end
    drain_results();

    // Random sets. Most are short and built from a small pool of triples in
    // shuffled side order, so repeats are common. Every twelfth set holds MAXE - 2
    // to MAXE + 6 triples, mostly enough to fill the store, then up to 8 repeats.
    while (sent < RAND_ITEMS || set_no < MIN_SETS) begin
      new_phase = (sent * 3) / RAND_ITEMS;
      if (new_phase > 2) new_phase = 2;
      if (new_phase != phase) begin
        drain_results();
        phase = new_phase;
        tx_idle_pct = (phase == 1) ? 50 : 0;
        rx_idle_pct = (phase == 1) ? 10 : 0;
      end
      if (set_no % 12 == 5) begin
        n_new = $urandom_range(MAXE + 6, MAXE - 2);
        n_rep = $urandom_range(8);
        big_q.delete();
        for (int k = 0; k < n_new; k++) begin
          t = '{SW'(k), rand_side(), SW'($urandom()), 1'b0};
          big_q = {big_q, t};
          t.last = (n_rep == 0 && k == n_new - 1);
          send_triangle(permute(t), 1'b0, '0);
        end
        for (int k = 0; k < n_rep; k++) begin
          t = big_q[$urandom_range(n_new - 1)];
          t.last = (k == n_rep - 1);
          send_triangle(permute(t), 1'b0, '0);
        end
        sent += n_new + n_rep;
      end else begin
        set_len = $urandom_range(12, 1);
        foreach (pool[j]) pool[j] = '{rand_side(), rand_side(), rand_side(), 1'b0};
        for (int k = 0; k < set_len; k++) begin
          if ($urandom_range(2) == 0) t = '{rand_side(), rand_side(), rand_side(), 1'b0};
          else t = permute(pool[$urandom_range(2)]);
          t.last = (k == set_len - 1);
          send_triangle(t, 1'b0, '0);
        end
        sent += set_len;
      end
      set_no++;
    end

    drain_results();
    repeat (MAXE + 20) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
